>>> rtl/wgcd_pkg.sv
// ----------------------------------------------------------------------------
// wgcd_pkg
// Shared constants for the wait-for graph cycle detector.
// ----------------------------------------------------------------------------
package wgcd_pkg;

  localparam int FUNC_W = 2;
  localparam int VTX_W  = 6;
  localparam int VCNT_W = 7;

  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CHECK  = 2'd2;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  localparam logic [VCNT_W-1:0] VCNT_RESET = 7'd64;

endpackage

>>> rtl/wait_graph_cycle_detector_top.sv
// ----------------------------------------------------------------------------
// wait_graph_cycle_detector_top
// Wait-for graph held as an adjacency bit matrix in RAM; add edge, remove
// edge, and depth-first cycle check.
//
// Input: an operation is taken on a rising edge with start high and busy low.
// in_func selects add (0), remove (1) or check (2); code 3 is an error.
// Output: out_valid pulses for one cycle with out_cycle_found and out_status;
// the receiver has no back-pressure, every result is taken that cycle.
// Config: cfg_data (vertex count) is written when cfg_valid is high; cfg_ready
// is always high. Write it only while busy is low.
// Flow: an error result appears in the cycle after the beat; add and remove
// run a row read, then a row write. A check walks the DFS sequencer: a scan
// step per start vertex, a row RAM read, evaluate and decide per push, and a
// stack RAM read per pop. The row RAM read port sets the pace.
// busy stays high from the accepted beat until the result cycle; an error beat
// never raises it. One item is in flight at a time.
// Reset clears all edges through per-row valid flops, no clearing pass is
// needed, and sets the vertex count to 64.
// ----------------------------------------------------------------------------
module wait_graph_cycle_detector_top #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [wgcd_pkg::FUNC_W-1:0] in_func,
  input  logic [wgcd_pkg::VTX_W-1:0]  in_from_vertex,
  input  logic [wgcd_pkg::VTX_W-1:0]  in_to_vertex,
  output logic                       out_valid,
  output logic                       out_cycle_found,
  output logic                       out_status,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [wgcd_pkg::VCNT_W-1:0] cfg_data
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int UW = (CW > wgcd_pkg::VCNT_W) ? CW : wgcd_pkg::VCNT_W;

  typedef enum logic [2:0] {
    S_IDLE, S_UPD_WR, S_SCAN, S_EVAL, S_DEC, S_POP
  } state_t;

  state_t state_r;

  logic [wgcd_pkg::VCNT_W-1:0] vcnt_r;
  logic [UW-1:0]               ucnt;
  logic [MAX_VERTICES-1:0]     cnt_mask;

  logic [MAX_VERTICES-1:0] row_vld_r;
  logic [MAX_VERTICES-1:0] visited_r;
  logic [MAX_VERTICES-1:0] onstack_r;
  logic [MAX_VERTICES-1:0] u_r;
  logic                    cyc_r;
  logic                    rvld_r;
  logic [CW-1:0]           depth_r;
  logic [UW-1:0]           s_r;
  logic [VW-1:0]           top_r;

  logic                    op_add_r;
  logic [VW-1:0]           op_from_r;
  logic [VW-1:0]           op_to_r;

  logic [VW-1:0]           adj_raddr;
  logic                    adj_we;
  logic [MAX_VERTICES-1:0] adj_wdata;
  logic [MAX_VERTICES-1:0] adj_rdata;
  logic [MAX_VERTICES-1:0] row_eff;
  logic [MAX_VERTICES-1:0] m_eval;

  logic                    stk_we;
  logic [VW-1:0]           stk_waddr;
  logic [VW-1:0]           stk_wdata;
  logic [VW-1:0]           stk_raddr;
  logic [VW-1:0]           stk_rdata;

  logic [VW-1:0]           pe_idx;
  logic                    accept;
  logic                    in_range;
  logic [VW-1:0]           s_idx;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign s_idx     = s_r[VW-1:0];

  always_comb begin
    if (UW'(vcnt_r) > UW'(MAX_VERTICES)) begin
      ucnt = UW'(MAX_VERTICES);
    end else begin
      ucnt = UW'(vcnt_r);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      cnt_mask[i] = (UW'(i) < ucnt);
    end
  end

  assign in_range = (UW'(in_from_vertex) < ucnt) && (UW'(in_to_vertex) < ucnt);

  always_comb begin
    pe_idx = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (u_r[i]) begin
        pe_idx = VW'(i);
      end
    end
  end

  assign row_eff = rvld_r ? adj_rdata : '0;
  assign m_eval  = row_eff & cnt_mask & ~(visited_r & ~onstack_r);

  always_comb begin
    case (state_r)
      S_IDLE:  adj_raddr = VW'(in_from_vertex);
      S_SCAN:  adj_raddr = s_idx;
      S_DEC:   adj_raddr = pe_idx;
      S_POP:   adj_raddr = stk_rdata;
      default: adj_raddr = top_r;
    endcase
  end

  always_comb begin
    adj_wdata = row_eff;
    adj_wdata[op_to_r] = op_add_r;
  end
  assign adj_we = (state_r == S_UPD_WR);

  assign stk_we    = ((state_r == S_SCAN) && (s_r < ucnt) && !visited_r[s_idx]) ||
                     ((state_r == S_DEC) && !cyc_r && (|u_r));
  assign stk_waddr = VW'(depth_r);
  assign stk_wdata = (state_r == S_SCAN) ? s_idx : pe_idx;
  assign stk_raddr = VW'(depth_r - CW'(2));

  wgcd_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (op_from_r),
    .wdata (adj_wdata),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  wgcd_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_stk_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  always_ff @(posedge clk) begin
    rvld_r <= row_vld_r[adj_raddr];
    if (accept) begin
      op_add_r  <= (in_func == wgcd_pkg::FUNC_ADD);
      op_from_r <= VW'(in_from_vertex);
      op_to_r   <= VW'(in_to_vertex);
    end
    if (state_r == S_EVAL) begin
      cyc_r <= |(m_eval & onstack_r);
      u_r   <= m_eval & ~visited_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      vcnt_r          <= wgcd_pkg::VCNT_RESET;
      row_vld_r       <= '0;
      visited_r       <= '0;
      onstack_r       <= '0;
      depth_r         <= '0;
      s_r             <= '0;
      top_r           <= '0;
      out_valid       <= 1'b0;
      out_cycle_found <= 1'b0;
      out_status      <= wgcd_pkg::STATUS_OK;
    end else begin
      out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        vcnt_r <= cfg_data;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_func == wgcd_pkg::FUNC_CHECK) begin
              visited_r <= '0;
              onstack_r <= '0;
              depth_r   <= '0;
              s_r       <= '0;
              state_r   <= S_SCAN;
            end else if ((in_func == wgcd_pkg::FUNC_ADD ||
                          in_func == wgcd_pkg::FUNC_REMOVE) && in_range) begin
              state_r <= S_UPD_WR;
            end else begin
              out_valid       <= 1'b1;
              out_cycle_found <= 1'b0;
              out_status      <= wgcd_pkg::STATUS_ERR;
            end
          end
        end
        S_UPD_WR: begin
          row_vld_r[op_from_r] <= 1'b1;
          out_valid            <= 1'b1;
          out_cycle_found      <= 1'b0;
          out_status           <= wgcd_pkg::STATUS_OK;
          state_r              <= S_IDLE;
        end
        S_SCAN: begin
          if (s_r >= ucnt) begin
            out_valid       <= 1'b1;
            out_cycle_found <= 1'b0;
            out_status      <= wgcd_pkg::STATUS_OK;
            state_r         <= S_IDLE;
          end else if (visited_r[s_idx]) begin
            s_r <= s_r + UW'(1);
          end else begin
            visited_r[s_idx] <= 1'b1;
            onstack_r[s_idx] <= 1'b1;
            top_r            <= s_idx;
            depth_r          <= CW'(1);
            state_r          <= S_EVAL;
          end
        end
        S_EVAL: begin
          state_r <= S_DEC;
        end
        S_DEC: begin
          if (cyc_r) begin
            out_valid       <= 1'b1;
            out_cycle_found <= 1'b1;
            out_status      <= wgcd_pkg::STATUS_OK;
            state_r         <= S_IDLE;
          end else if (|u_r) begin
            visited_r[pe_idx] <= 1'b1;
            onstack_r[pe_idx] <= 1'b1;
            top_r             <= pe_idx;
            depth_r           <= depth_r + CW'(1);
            state_r           <= S_EVAL;
          end else begin
            onstack_r[top_r] <= 1'b0;
            depth_r          <= depth_r - CW'(1);
            if (depth_r == CW'(1)) begin
              state_r <= S_SCAN;
            end else begin
              state_r <= S_POP;
            end
          end
        end
        S_POP: begin
          top_r   <= stk_rdata;
          state_r <= S_EVAL;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/wgcd_ram.sv
// ----------------------------------------------------------------------------
// wgcd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wgcd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> verif/wgcd_checker.sv
// ----------------------------------------------------------------------------
// wgcd_checker
// Watches the command, result and config channels of the wait-for graph
// cycle detector, keeps its own copy of the edge matrix and vertex count,
// predicts the outcome of every accepted beat and compares each result
// against the oldest pending prediction.
// ----------------------------------------------------------------------------
module wgcd_checker #(
  parameter int NUM_V = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic [wgcd_pkg::FUNC_W-1:0]  in_func,
  input  logic [wgcd_pkg::VTX_W-1:0]   in_from_vertex,
  input  logic [wgcd_pkg::VTX_W-1:0]   in_to_vertex,
  input  logic                         out_valid,
  input  logic                         out_cycle_found,
  input  logic                         out_status,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [wgcd_pkg::VCNT_W-1:0]  cfg_data,
  output int                           fail_count,
  output int                           pending_count,
  output int                           checks_seen,
  output int                           cycles_seen,
  output int                           errors_seen
);

  typedef struct packed {
    logic cycle_found;
    logic status;
  } outcome_t;

  logic [NUM_V-1:0]            edge_rows [NUM_V];
  logic [wgcd_pkg::VCNT_W-1:0] vertex_count;
  outcome_t                    outcome_q [$];
  outcome_t                    want;
  int                          mismatches;
  int                          n_checks;
  int                          n_cycles;
  int                          n_errors;

  // Applies one operation to the local graph and returns its outcome.
  function automatic outcome_t graph_outcome(input logic [wgcd_pkg::FUNC_W-1:0] func,
                                             input logic [wgcd_pkg::VTX_W-1:0] src,
                                             input logic [wgcd_pkg::VTX_W-1:0] dst);
    outcome_t         r;
    logic [NUM_V-1:0] live;
    logic             changed;
    int               n;
    r.cycle_found = 1'b0;
    r.status      = wgcd_pkg::STATUS_OK;
    n = (vertex_count > NUM_V) ? NUM_V : int'(vertex_count);
    case (func)
      wgcd_pkg::FUNC_ADD, wgcd_pkg::FUNC_REMOVE: begin
        if (int'(src) >= n || int'(dst) >= n) begin
          r.status = wgcd_pkg::STATUS_ERR;
        end else begin
          edge_rows[src][dst] = (func == wgcd_pkg::FUNC_ADD);
        end
      end
      wgcd_pkg::FUNC_CHECK: begin
        // peel off vertices with no edge into the survivors; any left over
        // each have a successor among themselves, so a cycle exists
        live = '0;
        for (int v = 0; v < n; v++) live[v] = 1'b1;
        changed = 1'b1;
        while (changed) begin
          changed = 1'b0;
          for (int v = 0; v < n; v++) begin
            if (live[v] && (edge_rows[v] & live) == '0) begin
              live[v] = 1'b0;
              changed = 1'b1;
            end
          end
        end
        r.cycle_found = |live;
      end
      default: r.status = wgcd_pkg::STATUS_ERR;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int v = 0; v < NUM_V; v++) edge_rows[v] = '0;
      vertex_count = wgcd_pkg::VCNT_RESET;
      outcome_q.delete();
      mismatches = 0;
      n_checks   = 0;
      n_cycles   = 0;
      n_errors   = 0;
    end else begin
      if (out_valid) begin
        if (outcome_q.size() == 0) begin
          $error("result beat with no pending prediction");
          mismatches++;
        end else begin
          want = outcome_q.pop_front();
          if (out_cycle_found !== want.cycle_found) begin
            $error("cycle_found: expected %0b, got %0b", want.cycle_found,
                   out_cycle_found);
            mismatches++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0b, got %0b", want.status, out_status);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        want = graph_outcome(in_func, in_from_vertex, in_to_vertex);
        outcome_q.push_back(want);
        if (in_func == wgcd_pkg::FUNC_CHECK) n_checks++;
        if (want.cycle_found) n_cycles++;
        if (want.status == wgcd_pkg::STATUS_ERR) n_errors++;
      end
      if (cfg_valid && cfg_ready) vertex_count = cfg_data;
    end
    fail_count    <= mismatches;
    pending_count <= outcome_q.size();
    checks_seen   <= n_checks;
    cycles_seen   <= n_cycles;
    errors_seen   <= n_errors;
  end

endmodule

>>> verif/wait_graph_cycle_detector_top_test.sv
// ----------------------------------------------------------------------------
// wait_graph_cycle_detector_top_test
// Drives add, remove and check beats into the cycle detector under a range
// of vertex counts, with bursty start timing, and lets wgcd_checker judge
// every result. Directed corner cases first, then random edge paths that
// are closed into cycles and torn down again, mixed with noise beats.
// ----------------------------------------------------------------------------
module wait_graph_cycle_detector_top_test;

  localparam logic [wgcd_pkg::FUNC_W-1:0] FUNC_UNKNOWN = 2'd3;
  localparam int                          NUM_V        = 64;

  logic                        clk            = 1'b0;
  logic                        rst_n          = 1'b0;
  logic                        start          = 1'b0;
  logic                        busy;
  logic [wgcd_pkg::FUNC_W-1:0] in_func        = '0;
  logic [wgcd_pkg::VTX_W-1:0]  in_from_vertex = '0;
  logic [wgcd_pkg::VTX_W-1:0]  in_to_vertex   = '0;
  logic                        out_valid;
  logic                        out_cycle_found;
  logic                        out_status;
  logic                        cfg_valid      = 1'b0;
  logic                        cfg_ready;
  logic [wgcd_pkg::VCNT_W-1:0] cfg_data       = '0;

  int fail_count;
  int pending_count;
  int checks_seen;
  int cycles_seen;
  int errors_seen;

  int ops_sent;
  int settings_used;
  int usable;
  int gap_max;
  int burst_left;
  logic [2*wgcd_pkg::VTX_W-1:0] stray_edges [$];

  always #10 clk = ~clk;

  wait_graph_cycle_detector_top #(.MAX_VERTICES(NUM_V)) i_dut (.*);

  wgcd_checker #(.NUM_V(NUM_V)) i_checker (.*);

  function automatic logic [wgcd_pkg::VTX_W-1:0] rand_vertex(input int hi);
    int r;
    r = $urandom_range(0, hi);
    return r[wgcd_pkg::VTX_W-1:0];
  endfunction

  task automatic issue_op(input logic [wgcd_pkg::FUNC_W-1:0] func,
                          input logic [wgcd_pkg::VTX_W-1:0] src,
                          input logic [wgcd_pkg::VTX_W-1:0] dst);
    start          <= 1'b1;
    in_func        <= func;
    in_from_vertex <= src;
    in_to_vertex   <= dst;
    do @(posedge clk); while (busy);
    ops_sent++;
    if (gap_max > 0) begin
      if (burst_left == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
        burst_left = $urandom_range(0, 16);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  task automatic write_count(input logic [wgcd_pkg::VCNT_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    usable = (value > NUM_V) ? NUM_V : int'(value);
    settings_used++;
  endtask

  function automatic logic [wgcd_pkg::VTX_W-1:0] pick_vertex();
    if (usable == 0 || $urandom_range(0, 15) == 0) return rand_vertex(NUM_V - 1);
    return rand_vertex(usable - 1);
  endfunction

  // chain of adds, optionally closed back to its head, then removed again
  task automatic run_path();
    logic [wgcd_pkg::VTX_W-1:0] path [$];
    int k;
    bit closed;
    k = $urandom_range(2, 9);
    closed = ($urandom_range(0, 1) == 1);
    for (int i = 0; i < k; i++) path.push_back(pick_vertex());
    for (int i = 0; i < k - 1; i++) issue_op(wgcd_pkg::FUNC_ADD, path[i], path[i+1]);
    issue_op(wgcd_pkg::FUNC_CHECK, rand_vertex(NUM_V - 1), rand_vertex(NUM_V - 1));
    if (closed) begin
      issue_op(wgcd_pkg::FUNC_ADD, path[k-1], path[0]);
      issue_op(wgcd_pkg::FUNC_CHECK, rand_vertex(NUM_V - 1), rand_vertex(NUM_V - 1));
      issue_op(wgcd_pkg::FUNC_REMOVE, path[k-1], path[0]);
    end
    for (int i = k - 2; i >= 0; i--) begin
      issue_op(wgcd_pkg::FUNC_REMOVE, path[i], path[i+1]);
      if (i == (k - 1) / 2) begin
        issue_op(wgcd_pkg::FUNC_CHECK, rand_vertex(NUM_V - 1), rand_vertex(NUM_V - 1));
      end
    end
    issue_op(wgcd_pkg::FUNC_CHECK, rand_vertex(NUM_V - 1), rand_vertex(NUM_V - 1));
  endtask

  initial begin
    logic [wgcd_pkg::VCNT_W-1:0] counts [11];
    logic [wgcd_pkg::FUNC_W-1:0] func;
    logic [wgcd_pkg::VTX_W-1:0]  src;
    logic [wgcd_pkg::VTX_W-1:0]  dst;
    int                          target;
    int                          pick;
    counts = '{7'd64, 7'd8, 7'd1, 7'd0, 7'd127, 7'd33, 7'd2, 7'd16, 7'd100, 7'd5, 7'd64};
    ops_sent      = 0;
    settings_used = 0;
    usable        = NUM_V;
    gap_max       = 0;
    burst_left    = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed corner cases, back to back
    issue_op(wgcd_pkg::FUNC_CHECK, 6'd0, 6'd0);
    issue_op(wgcd_pkg::FUNC_ADD, 6'd0, 6'd63);
    issue_op(wgcd_pkg::FUNC_ADD, 6'd63, 6'd0);
    issue_op(wgcd_pkg::FUNC_CHECK, 6'd63, 6'd63);
    issue_op(wgcd_pkg::FUNC_REMOVE, 6'd63, 6'd0);
    issue_op(wgcd_pkg::FUNC_REMOVE, 6'd63, 6'd0);
    issue_op(wgcd_pkg::FUNC_CHECK, 6'd0, 6'd0);
    issue_op(wgcd_pkg::FUNC_ADD, 6'd21, 6'd21);
    issue_op(wgcd_pkg::FUNC_ADD, 6'd21, 6'd21);
    issue_op(wgcd_pkg::FUNC_CHECK, 6'd42, 6'd21);
    issue_op(wgcd_pkg::FUNC_REMOVE, 6'd21, 6'd21);
    issue_op(wgcd_pkg::FUNC_CHECK, 6'd0, 6'd0);
    issue_op(FUNC_UNKNOWN, 6'd42, 6'd21);
    issue_op(wgcd_pkg::FUNC_ADD, 6'd42, 6'd10);
    issue_op(wgcd_pkg::FUNC_ADD, 6'd10, 6'd42);
    issue_op(wgcd_pkg::FUNC_CHECK, 6'd0, 6'd0);
    write_count(7'd20);
    issue_op(wgcd_pkg::FUNC_CHECK, 6'd0, 6'd0);
    issue_op(wgcd_pkg::FUNC_ADD, 6'd42, 6'd10);
    issue_op(wgcd_pkg::FUNC_ADD, 6'd10, 6'd19);
    issue_op(wgcd_pkg::FUNC_REMOVE, 6'd19, 6'd20);
    write_count(7'd0);
    issue_op(wgcd_pkg::FUNC_ADD, 6'd0, 6'd0);
    issue_op(wgcd_pkg::FUNC_CHECK, 6'd0, 6'd0);
    issue_op(wgcd_pkg::FUNC_REMOVE, 6'd0, 6'd0);

    // random phases, one per vertex-count setting
    target = ops_sent;
    foreach (counts[p]) begin
      write_count(counts[p]);
      case (p % 4)
        0: gap_max = 0;
        1: gap_max = 4;
        2: gap_max = 12;
        default: gap_max = 30;
      endcase
      target += 130;
      while (ops_sent < target) begin
        if ($urandom_range(0, 4) == 0) begin
          pick = $urandom_range(0, 3);
          func = pick[wgcd_pkg::FUNC_W-1:0];
          src  = rand_vertex(NUM_V - 1);
          dst  = rand_vertex(NUM_V - 1);
          if (func == wgcd_pkg::FUNC_ADD) stray_edges.push_back({src, dst});
          issue_op(func, src, dst);
        end else begin
          run_path();
        end
        if ($urandom_range(0, 40) == 0) drain();
      end
      while (stray_edges.size() != 0) begin
        {src, dst} = stray_edges.pop_front();
        issue_op(wgcd_pkg::FUNC_REMOVE, src, dst);
      end
      issue_op(wgcd_pkg::FUNC_CHECK, rand_vertex(NUM_V - 1), rand_vertex(NUM_V - 1));
    end

    drain();
    repeat (20) @(posedge clk);
    $display("Ran %0d operations under %0d vertex-count settings.", ops_sent, settings_used);
    $display("%0d cycle checks (%0d found a cycle), %0d error results.", checks_seen,
             cycles_seen, errors_seen);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("Timeout: results still pending");
    $display("FAILED: results differ");
    $finish;
  end

endmodule
